@@ hdl/btbfa_pkg.sv @@
// shared types and constants for the boundary tag best fit allocator
// used by btbfa_ctrl, btbfa_dp and the top level; no dependencies
`timescale 1ns / 1ps

package btbfa_pkg;

  localparam int HEAP_WORDS = 1024;
  localparam int ADDR_W     = 10;
  localparam int TAG_W      = 10;
  localparam int POOL_W     = 11;
  localparam int BYTES_W    = 16;
  localparam int T_W        = 15;

  localparam logic [POOL_W-1:0] POOL_RESET = 11'd1024;
  localparam logic [ADDR_W-1:0] RESET_END  = 10'd1023;

  typedef enum logic [1:0] {
    OP_FORMAT  = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_UNDEF   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_NOOP    = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_CLR_RST, S_IDLE, S_DISP, S_CLR_FMT,
    S_A_RD, S_A_EV, S_A_FIN, S_SP1, S_SP2, S_SP3, S_EX1, S_EX2,
    S_R_EVH, S_R_EVP, S_R_POS, S_R_EVQ, S_R_W0, S_R_W1,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    ADR_CLR, ADR_WALK, ADR_HEAD, ADR_PRE, ADR_POS,
    ADR_SP0, ADR_SP1, ADR_SP2, ADR_SP3, ADR_R0, ADR_R1
  } adr_sel_t;

  typedef enum logic [2:0] {
    WD_CLR, WD_TM1, WD_LEFT, WD_USED, WD_MERGE, WD_RDSET
  } wd_sel_t;

  typedef enum logic [1:0] {
    RES_OK, RES_NOSPACE, RES_NOOP, RES_GRANT
  } res_sel_t;

  typedef struct packed {
    logic     mem_rd;
    logic     mem_wr;
    adr_sel_t adr;
    wd_sel_t  wd;
    logic     start;
    logic     fmt_init;
    logic     clr_step;
    logic     a_eval;
    logic     r_head;
    logic     r_pre;
    logic     r_pos;
    logic     res_ld;
    res_sel_t res;
    logic     out_ld;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       clr_last;
    logic       walk_end;
    logic       exact;
    logic       found;
    logic       split;
    logic       blk_bad;
    logic       head_bad;
    logic       pre_chk;
    logic       pos_chk;
    logic       out_busy;
  } sts_t;

endpackage

@@ hdl/btbfa_ctrl.sv @@
// controller state machine for the allocator
// depends on btbfa_pkg; drives btbfa_dp through cmd_t, reads sts_t
`timescale 1ns / 1ps

module btbfa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  btbfa_pkg::sts_t   sts,
  output btbfa_pkg::cmd_t   cmd,
  output logic              idle
);
  import btbfa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR_RST;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign idle = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.adr   = ADR_CLR;
    cmd.wd    = WD_CLR;
    cmd.res   = RES_OK;
    case (state_r)
      S_CLR_RST, S_CLR_FMT: begin
        cmd.mem_wr   = 1'b1;
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = (state_r == S_CLR_RST) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd.start = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          OP_FORMAT: begin
            cmd.fmt_init = 1'b1;
            cmd.res_ld   = 1'b1;
            cmd.res      = RES_OK;
            state_nxt    = S_CLR_FMT;
          end
          OP_ALLOC: state_nxt = S_A_RD;
          OP_RELEASE: begin
            if (sts.blk_bad) begin
              cmd.res_ld = 1'b1;
              cmd.res    = RES_NOOP;
              state_nxt  = S_DONE;
            end else begin
              cmd.mem_rd = 1'b1;
              cmd.adr    = ADR_HEAD;
              state_nxt  = S_R_EVH;
            end
          end
          default: begin
            cmd.res_ld = 1'b1;
            cmd.res    = RES_NOOP;
            state_nxt  = S_DONE;
          end
        endcase
      end
      S_A_RD: begin
        if (sts.walk_end) begin
          state_nxt = S_A_FIN;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.adr    = ADR_WALK;
          state_nxt  = S_A_EV;
        end
      end
      S_A_EV: begin
        cmd.a_eval = 1'b1;
        state_nxt  = sts.exact ? S_A_FIN : S_A_RD;
      end
      S_A_FIN: begin
        if (!sts.found) begin
          cmd.res_ld = 1'b1;
          cmd.res    = RES_NOSPACE;
          state_nxt  = S_DONE;
        end else if (sts.split) begin
          cmd.mem_wr = 1'b1;
          cmd.adr    = ADR_SP0;
          cmd.wd     = WD_TM1;
          state_nxt  = S_SP1;
        end else begin
          // exact fit keeps the tail tag as it is and only sets its in-use bit
          cmd.mem_rd = 1'b1;
          cmd.adr    = ADR_SP3;
          state_nxt  = S_EX1;
        end
      end
      S_SP1: begin
        cmd.mem_wr = 1'b1;
        cmd.adr    = ADR_SP1;
        cmd.wd     = WD_TM1;
        state_nxt  = S_SP2;
      end
      S_SP2: begin
        cmd.mem_wr = 1'b1;
        cmd.adr    = ADR_SP2;
        cmd.wd     = WD_LEFT;
        state_nxt  = S_SP3;
      end
      S_SP3: begin
        cmd.mem_wr = 1'b1;
        cmd.adr    = ADR_SP3;
        cmd.wd     = WD_LEFT;
        cmd.res_ld = 1'b1;
        cmd.res    = RES_GRANT;
        state_nxt  = S_DONE;
      end
      S_EX1: begin
        cmd.mem_wr = 1'b1;
        cmd.adr    = ADR_SP0;
        cmd.wd     = WD_USED;
        state_nxt  = S_EX2;
      end
      S_EX2: begin
        cmd.mem_wr = 1'b1;
        cmd.adr    = ADR_SP3;
        cmd.wd     = WD_RDSET;
        cmd.res_ld = 1'b1;
        cmd.res    = RES_GRANT;
        state_nxt  = S_DONE;
      end
      S_R_EVH: begin
        cmd.r_head = 1'b1;
        if (sts.head_bad) begin
          cmd.res_ld = 1'b1;
          cmd.res    = RES_NOOP;
          state_nxt  = S_DONE;
        end else if (sts.pre_chk) begin
          cmd.mem_rd = 1'b1;
          cmd.adr    = ADR_PRE;
          state_nxt  = S_R_EVP;
        end else begin
          state_nxt = S_R_POS;
        end
      end
      S_R_EVP: begin
        cmd.r_pre = 1'b1;
        state_nxt = S_R_POS;
      end
      S_R_POS: begin
        if (sts.pos_chk) begin
          cmd.mem_rd = 1'b1;
          cmd.adr    = ADR_POS;
          state_nxt  = S_R_EVQ;
        end else begin
          state_nxt = S_R_W0;
        end
      end
      S_R_EVQ: begin
        cmd.r_pos = 1'b1;
        state_nxt = S_R_W0;
      end
      S_R_W0: begin
        cmd.mem_wr = 1'b1;
        cmd.adr    = ADR_R0;
        cmd.wd     = WD_MERGE;
        state_nxt  = S_R_W1;
      end
      S_R_W1: begin
        cmd.mem_wr = 1'b1;
        cmd.adr    = ADR_R1;
        cmd.wd     = WD_MERGE;
        cmd.res_ld = 1'b1;
        cmd.res    = RES_OK;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ hdl/btbfa_dp.sv @@
// datapath: tag store, walk and release registers, config and result registers
// depends on btbfa_pkg; commanded by btbfa_ctrl
`timescale 1ns / 1ps

module btbfa_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  btbfa_pkg::cmd_t                 cmd,
  output btbfa_pkg::sts_t                 sts,
  input  logic [1:0]                      in_op,
  input  logic [btbfa_pkg::BYTES_W-1:0]   in_bytes,
  input  logic [btbfa_pkg::ADDR_W-1:0]    in_idx,
  input  logic                            cfg_we,
  input  logic [btbfa_pkg::POOL_W-1:0]    cfg_wdata,
  input  logic                            out_take,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [btbfa_pkg::ADDR_W-1:0]    out_granted
);
  import btbfa_pkg::*;

  logic [TAG_W-1:0] mem [HEAP_WORDS];
  logic [TAG_W-1:0] rd_data_r;

  logic [POOL_W-1:0] pool_r;
  logic [ADDR_W-1:0] end_r, end_nxt;
  logic [ADDR_W-1:0] cnt_r;
  logic [1:0]        op_r;
  logic [T_W-1:0]    t_r;
  logic [ADDR_W:0]   i_r;
  logic [ADDR_W-1:0] best_i_r, best_s_r, best_left_r;
  logic              found_r, split_r;
  logic [ADDR_W-1:0] blk_r, s_r, tail_r, pre_s_r, pre_hd_r, pos_s_r, pos_tl_r;
  logic              prev_open_r, next_open_r;
  logic [1:0]        res_status_r;
  logic [ADDR_W-1:0] res_granted_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [ADDR_W-1:0] out_granted_r;

  logic [POOL_W-1:0] p_min, p_even;
  logic [TAG_W-1:0]  s_c;
  logic              fits_c, free_c, exact_c, better_c;
  logic [ADDR_W:0]   tail_c, pos_hd_c;
  logic [ADDR_W-1:0] pre_tl_c;
  logic [ADDR_W-1:0] addr_c;
  logic [TAG_W-1:0]  wdata_c, merge_c;
  logic [BYTES_W:0]  bsum_c;

  // pool size for the next format
  always_comb begin
    p_min  = (pool_r > POOL_W'(HEAP_WORDS)) ? POOL_W'(HEAP_WORDS) : pool_r;
    p_even = {p_min[POOL_W-1:1], 1'b0};
    if (p_even < POOL_W'(2)) p_even = POOL_W'(2);
    end_nxt = ADDR_W'(p_even - POOL_W'(1));
  end

  // walk evaluation of the tag just read
  always_comb begin
    s_c      = {rd_data_r[TAG_W-1:1], 1'b0};
    free_c   = !rd_data_r[0];
    fits_c   = ({1'b0, i_r} + 12'd1 + {2'b0, s_c}) <= {2'b0, end_r};
    exact_c  = free_c && fits_c && ({5'b0, s_c} == (t_r - T_W'(2)));
    better_c = free_c && fits_c && ({5'b0, s_c} >= t_r) &&
               (!found_r || (ADDR_W'({5'b0, s_c} - t_r) < best_left_r));
  end

  assign tail_c   = {1'b0, blk_r} + {1'b0, rd_data_r} - 11'd1;
  assign pre_tl_c = blk_r - ADDR_W'(2);
  assign pos_hd_c = {1'b0, tail_r} + 11'd1;

  always_comb begin
    merge_c = s_r;
    if (prev_open_r) merge_c = merge_c + pre_s_r + TAG_W'(2);
    if (next_open_r) merge_c = merge_c + pos_s_r + TAG_W'(2);
  end

  always_comb begin
    case (cmd.adr)
      ADR_CLR:  addr_c = cnt_r;
      ADR_WALK: addr_c = i_r[ADDR_W-1:0];
      ADR_HEAD: addr_c = blk_r - ADDR_W'(1);
      ADR_PRE:  addr_c = pre_tl_c;
      ADR_POS:  addr_c = pos_hd_c[ADDR_W-1:0];
      ADR_SP0:  addr_c = best_i_r;
      ADR_SP1:  addr_c = best_i_r + t_r[ADDR_W-1:0] - ADDR_W'(1);
      ADR_SP2:  addr_c = best_i_r + t_r[ADDR_W-1:0];
      ADR_SP3:  addr_c = best_i_r + ADDR_W'(1) + best_s_r;
      ADR_R0:   addr_c = prev_open_r ? pre_hd_r : blk_r - ADDR_W'(1);
      ADR_R1:   addr_c = next_open_r ? pos_tl_r : tail_r;
      default:  addr_c = cnt_r;
    endcase
  end

  always_comb begin
    case (cmd.wd)
      WD_CLR:   wdata_c = (cnt_r == '0 || cnt_r == end_r) ? end_r - TAG_W'(1) : '0;
      WD_TM1:   wdata_c = t_r[TAG_W-1:0] - TAG_W'(1);
      WD_LEFT:  wdata_c = best_s_r - t_r[TAG_W-1:0];
      WD_USED:  wdata_c = best_s_r | TAG_W'(1);
      WD_MERGE: wdata_c = merge_c;
      WD_RDSET: wdata_c = rd_data_r | TAG_W'(1);
      default:  wdata_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[addr_c] <= wdata_c;
    if (cmd.mem_rd) rd_data_r <= mem[addr_c];
  end

  assign bsum_c = {1'b0, in_bytes} + 17'd15;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r      <= POOL_RESET;
      end_r       <= RESET_END;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) pool_r <= cfg_wdata;
      if (cmd.fmt_init) begin
        end_r <= end_nxt;
        cnt_r <= '0;
      end else if (cmd.clr_step) begin
        cnt_r <= (cnt_r == end_r) ? '0 : cnt_r + ADDR_W'(1);
      end
      if (cmd.out_ld) out_valid_r <= 1'b1;
      else if (out_take) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r    <= in_op;
      blk_r   <= in_idx;
      t_r     <= {bsum_c[BYTES_W:3], 1'b0};
      i_r     <= '0;
      found_r <= 1'b0;
      split_r <= 1'b0;
    end
    if (cmd.a_eval) begin
      if (exact_c) begin
        found_r  <= 1'b1;
        split_r  <= 1'b0;
        best_i_r <= i_r[ADDR_W-1:0];
        best_s_r <= s_c;
      end else if (better_c) begin
        found_r     <= 1'b1;
        split_r     <= 1'b1;
        best_i_r    <= i_r[ADDR_W-1:0];
        best_s_r    <= s_c;
        best_left_r <= ADDR_W'({5'b0, s_c} - t_r);
      end
      i_r <= i_r + {1'b0, s_c} + 11'd2;
    end
    if (cmd.r_head) begin
      s_r         <= rd_data_r - TAG_W'(1);
      tail_r      <= tail_c[ADDR_W-1:0];
      prev_open_r <= 1'b0;
      next_open_r <= 1'b0;
    end
    if (cmd.r_pre) begin
      prev_open_r <= !rd_data_r[0] && ({1'b0, rd_data_r} + 11'd1 <= {1'b0, pre_tl_c});
      pre_s_r     <= rd_data_r;
      pre_hd_r    <= pre_tl_c - rd_data_r - ADDR_W'(1);
    end
    if (cmd.r_pos) begin
      next_open_r <= !rd_data_r[0] &&
                     ({1'b0, pos_hd_c} + 12'd1 + {2'b0, rd_data_r} <= {2'b0, end_r});
      pos_s_r     <= rd_data_r;
      pos_tl_r    <= pos_hd_c[ADDR_W-1:0] + ADDR_W'(1) + rd_data_r;
    end
    if (cmd.res_ld) begin
      case (cmd.res)
        RES_OK: begin
          res_status_r  <= ST_DONE;
          res_granted_r <= '0;
        end
        RES_NOSPACE: begin
          res_status_r  <= ST_NOSPACE;
          res_granted_r <= '0;
        end
        RES_GRANT: begin
          res_status_r  <= ST_DONE;
          res_granted_r <= best_i_r + ADDR_W'(1);
        end
        default: begin
          res_status_r  <= ST_NOOP;
          res_granted_r <= '0;
        end
      endcase
    end
    if (cmd.out_ld) begin
      out_status_r  <= res_status_r;
      out_granted_r <= res_granted_r;
    end
  end

  always_comb begin
    sts.op       = op_r;
    sts.clr_last = (cnt_r == end_r);
    sts.walk_end = (i_r >= {1'b0, end_r});
    sts.exact    = exact_c;
    sts.found    = found_r;
    sts.split    = split_r;
    sts.blk_bad  = (blk_r == '0) || (blk_r > end_r);
    sts.head_bad = !rd_data_r[0] || (tail_c > {1'b0, end_r});
    sts.pre_chk  = (blk_r >= ADDR_W'(3));
    sts.pos_chk  = (pos_hd_c < {1'b0, end_r});
    sts.out_busy = out_valid_r && !out_take;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_granted = out_granted_r;

endmodule

@@ hdl/boundary_tag_best_fit_allocator.sv @@
// boundary tag best fit allocator; format clears the pool and lays one free block over it;
// allocate walks the blocks, reading each tag from the single-port store in turn, and
// ends with no room, an exact fit or a split; release is refused on a bad index or head,
// else merges with free neighbours; one word in flight; in_tready rises with out_tvalid,
// a result register frees the output side; reset: synchronous active-low; a clearing pass
// over all 1024 words lays one free block over the pool, during which no word is accepted
`timescale 1ns / 1ps

module boundary_tag_best_fit_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,  // request_bytes, payload_index, zero pad
  input  logic [1:0]                    in_tuser,  // opcode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata, // granted_index, zero pad
  output logic [1:0]                    out_tuser, // status
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [btbfa_pkg::POOL_W-1:0]  cfg_data   // pool_words
);
  import btbfa_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic              idle;
  logic [ADDR_W-1:0] granted;

  assign in_tready = idle;
  assign cfg_ready = 1'b1;

  btbfa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_tvalid && idle),
    .sts     (sts),
    .cmd     (cmd),
    .idle    (idle)
  );

  btbfa_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (in_tuser),
    .in_bytes    (in_tdata[15:0]),
    .in_idx      (in_tdata[25:16]),
    .cfg_we      (cfg_valid),
    .cfg_wdata   (cfg_data),
    .out_take    (out_tready),
    .out_valid   (out_tvalid),
    .out_status  (out_tuser),
    .out_granted (granted)
  );

  assign out_tdata = {6'b0, granted};

endmodule

@@ tb/sv/boundary_tag_best_fit_allocator_tb.sv @@
// testbench for the boundary tag best fit allocator: drives formats, allocates and
// releases through the stream ports and checks every result word against a heap model
// depends on btbfa_pkg and the boundary_tag_best_fit_allocator top level
`timescale 1ns / 1ps

class heap_scoreboard;
  int unsigned tags[1024];
  int unsigned last_tag;
  int unsigned pool_setting;
  logic [1:0]  exp_status[$];
  logic [9:0]  exp_grant[$];
  int          mismatches;
  int          results_seen;
  int unsigned live_blocks[$];

  function void lay_pool();
    int unsigned p;
    p = pool_setting;
    if (p > 1024) p = 1024;
    p = p & ~32'd1;
    if (p < 2) p = 2;
    foreach (tags[k]) tags[k] = 0;
    last_tag = p - 1;
    tags[0] = p - 2;
    tags[p-1] = p - 2;
    live_blocks.delete();
  endfunction

  function void reset_state();
    pool_setting = 1024;
    lay_pool();
    exp_status.delete();
    exp_grant.delete();
    mismatches = 0;
    results_seen = 0;
  endfunction

  function void place(int unsigned bytes, output logic [1:0] st, output logic [9:0] g);
    int unsigned t, i, best_i, best_s, best_left, tag, s;
    bit found, split;
    t = ((bytes + 15) / 8) * 2;
    i = 0; best_i = 0; best_s = 0; best_left = 0; found = 0; split = 0;
    while (i < last_tag) begin
      tag = tags[i];
      s = tag & ~32'd1;
      if ((tag & 1) == 0 && i + 1 + s <= last_tag) begin
        if (s == t - 2) begin
          found = 1; split = 0; best_i = i; best_s = s;
          break;
        end
        if (s >= t && (!found || s - t < best_left)) begin
          found = 1; split = 1; best_i = i; best_s = s; best_left = s - t;
        end
      end
      i += s + 2;
    end
    g = 0;
    if (!found) begin
      st = btbfa_pkg::ST_NOSPACE;
      return;
    end
    if (split) begin
      tags[best_i] = t - 1;
      tags[best_i + t - 1] = t - 1;
      tags[best_i + t] = best_s - t;
      tags[best_i + 1 + best_s] = best_s - t;
    end else begin
      tags[best_i] |= 1;
      tags[best_i + 1 + best_s] |= 1;
    end
    g = 10'(best_i + 1);
    live_blocks.push_back(best_i + 1);
    st = btbfa_pkg::ST_DONE;
  endfunction

  function logic [1:0] free_block(int unsigned blk);
    int unsigned head, s, tail, pre_s, pos_s, pre_hd, pos_hd, pos_tl, pre_tl, v, sum;
    bit prev_open, next_open;
    pre_s = 0; pos_s = 0; pre_hd = 0; pos_tl = 0; prev_open = 0; next_open = 0;
    if (blk == 0 || blk > last_tag) return btbfa_pkg::ST_NOOP;
    head = blk - 1;
    if ((tags[head] & 1) == 0) return btbfa_pkg::ST_NOOP;
    s = tags[head] - 1;
    tail = blk + s;
    if (tail > last_tag) return btbfa_pkg::ST_NOOP;
    if (blk >= 3) begin
      pre_tl = blk - 2;
      v = tags[pre_tl];
      if ((v & 1) == 0 && v + 1 <= pre_tl) begin
        prev_open = 1; pre_s = v; pre_hd = pre_tl - v - 1;
      end
    end
    pos_hd = tail + 1;
    if (pos_hd < last_tag) begin
      v = tags[pos_hd];
      if ((v & 1) == 0 && pos_hd + 1 + v <= last_tag) begin
        next_open = 1; pos_s = v; pos_tl = pos_hd + 1 + v;
      end
    end
    sum = s + (prev_open ? pre_s + 2 : 0) + (next_open ? pos_s + 2 : 0);
    tags[prev_open ? pre_hd : head] = sum;
    tags[next_open ? pos_tl : tail] = sum;
    return btbfa_pkg::ST_DONE;
  endfunction

  function void note_word(logic [1:0] op, logic [15:0] bytes, logic [9:0] idx);
    logic [1:0] st;
    logic [9:0] g;
    g = 0;
    case (op)
      btbfa_pkg::OP_FORMAT: begin
        lay_pool();
        st = btbfa_pkg::ST_DONE;
      end
      btbfa_pkg::OP_ALLOC: place(bytes, st, g);
      btbfa_pkg::OP_RELEASE: st = free_block(idx);
      default: st = btbfa_pkg::ST_NOOP;
    endcase
    exp_status.push_back(st);
    exp_grant.push_back(g);
  endfunction

  function void check_word(logic [1:0] st, logic [15:0] data);
    logic [1:0] es;
    logic [9:0] eg;
    results_seen++;
    if (exp_status.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word: status %0d data %0h", st, data);
      return;
    end
    es = exp_status.pop_front();
    eg = exp_grant.pop_front();
    if (st !== es || data !== {6'd0, eg}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch at result %0d: status exp %0d got %0d, index exp %0d got %0h",
                 results_seen, es, st, eg, data);
    end
  endfunction
endclass

module boundary_tag_best_fit_allocator_tb;
  import btbfa_pkg::*;

  localparam int LIMIT = 3000000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = 0;
  logic [1:0]  in_tuser = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [POOL_W-1:0] cfg_data = 0;

  heap_scoreboard heap_sb = new();
  int send_gap_pct = 12;
  int recv_gap_pct = 47;
  int hold_off_cycles = 0;
  int cycle_count = 0;
  int words_sent = 0;

  boundary_tag_best_fit_allocator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("boundary_tag_best_fit_allocator_tb: FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off counted here
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) heap_sb.check_word(out_tuser, out_tdata);
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // valid stays up after a word is taken so that the next word can follow at once;
  // idle gaps and drain() drop it
  task automatic send_word(logic [1:0] op, logic [15:0] bytes, logic [9:0] idx);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, idx, bytes};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    heap_sb.note_word(op, bytes, idx);
    words_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (heap_sb.exp_status.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_pool(logic [POOL_W-1:0] value);
    drain();
    cfg_valid <= 1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    heap_sb.pool_setting = value;
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [9:0] pick_release();
    int k;
    logic [9:0] r;
    if (heap_sb.live_blocks.size() == 0 || $urandom_range(9) == 0)
      return 10'($urandom_range(1023));
    k = $urandom_range(heap_sb.live_blocks.size() - 1);
    r = 10'(heap_sb.live_blocks[k]);
    heap_sb.live_blocks.delete(k);
    return r;
  endfunction

  task automatic random_words(int count);
    int r;
    logic [15:0] b;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 2) send_word(OP_FORMAT, 16'($urandom), 10'($urandom));
      else if (r < 4) send_word(OP_UNDEF, 16'($urandom), 10'($urandom));
      else if (r < 55) begin
        case ($urandom_range(9))
          0: b = 16'($urandom);
          1: b = 0;
          2, 3: b = 16'($urandom_range(255));
          default: b = 16'($urandom_range(64));
        endcase
        send_word(OP_ALLOC, b, 10'($urandom));
      end else send_word(OP_RELEASE, 16'($urandom), pick_release());
    end
  endtask

  task automatic phase(int sgap, int rgap, logic [POOL_W-1:0] pool, int count);
    send_gap_pct = sgap;
    recv_gap_pct = rgap;
    write_pool(pool);
    send_word(OP_FORMAT, 0, 0);
    random_words(count);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;
    heap_sb.reset_state();
    @(posedge clk);

    // directed: exact fit, splits, zero size leftover, merges, bad releases, odd opcode
    send_word(OP_ALLOC, 0, 0);
    send_word(OP_ALLOC, 16'hffff, 0);
    send_word(OP_ALLOC, 8, 0);
    send_word(OP_ALLOC, 1, 0);
    send_word(OP_ALLOC, 24, 0);
    send_word(OP_RELEASE, 0, 0);
    send_word(OP_RELEASE, 0, 10'd1023);
    send_word(OP_RELEASE, 0, 3);
    send_word(OP_RELEASE, 0, 7);
    send_word(OP_RELEASE, 0, 7);
    send_word(OP_RELEASE, 0, 1);
    send_word(OP_UNDEF, 16'hffff, 10'h3ff);
    write_pool(11'd2047);
    send_word(OP_FORMAT, 0, 0);
    send_word(OP_ALLOC, 16'd8176, 0);
    send_word(OP_RELEASE, 0, 1);
    write_pool(11'd1);
    send_word(OP_FORMAT, 0, 0);
    send_word(OP_ALLOC, 0, 0);
    send_word(OP_ALLOC, 0, 0);
    send_word(OP_RELEASE, 0, 1);
    write_pool(11'd4);
    send_word(OP_FORMAT, 0, 0);
    send_word(OP_ALLOC, 0, 0);
    send_word(OP_ALLOC, 1, 0);
    send_word(OP_RELEASE, 0, 1);

    phase(12, 47, 11'd1024, 250);
    // long receiver hold-off while the sender keeps pushing words
    hold_off_cycles = 400;
    random_words(30);
    phase(47, 12, 11'd64, 250);
    drain();
    phase(0, 0, 11'd301, 200);
    phase(0, 0, 11'd4, 40);
    phase(0, 0, 11'd1024, 250);
    drain();

    $display("covered %0d words over pools of 2 to 1024 words with formats, best fit",
             words_sent);
    $display("allocates, merging releases, bad releases and an undefined opcode");
    if (heap_sb.mismatches == 0 && heap_sb.exp_status.size() == 0)
      $display("boundary_tag_best_fit_allocator_tb: PASS");
    else
      $display("boundary_tag_best_fit_allocator_tb: FAIL");
    $finish;
  end
endmodule
